// File: sv/complex_arithmetic_unit_core_assert.svh
// Assertion macros used by the complex ALU sequencer.
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Concurrent property check on the rising clock edge, off during reset.
`define CAU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// Condition that must never be seen on a clock edge.
`define CAU_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define CAU_ASSERT(lbl, clk, rstn, prop)
`define CAU_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// File: sv/cau_pkg.sv
// Types, codes and saturation helpers of the complex ALU.
package cau_pkg;

  typedef enum logic [3:0] {
    F_ADD     = 4'd0,
    F_SUB     = 4'd1,
    F_MUL     = 4'd2,
    F_DIV     = 4'd3,
    F_CONJ    = 4'd4,
    F_MOD     = 4'd5,
    F_SQUARE  = 4'd6,
    F_INV     = 4'd7,
    F_POW     = 4'd8,
    F_SCALE   = 4'd9,
    F_ADDREAL = 4'd10,
    F_SUBREAL = 4'd11,
    F_DIVREAL = 4'd12
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  // Product selection of the shared multiplier; also the accumulate tag.
  typedef enum logic [2:0] {
    MS_NONE,
    MS_XRYR,
    MS_XIYI,
    MS_XRYI,
    MS_XIYR,
    MS_YRYR,
    MS_YIYI
  } msel_e;

  localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic  load;
    msel_e msel;
    logic  mul_wb;
    logic  div_init;
    logic  div_step;
    logic  div_wb;
    logic  sqrt_init;
    logic  sqrt_step;
    logic  sqrt_wb;
    logic  fin;
  } cmd_t;

  // Sign and magnitude to 32-bit signed, clamped. Returns {sat, value}.
  function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [32:0] r;
    if (neg) begin
      if (mag > 64'h8000_0000) r = {1'b1, S32_MIN};
      else                     r = {1'b0, 32'(32'd0 - mag[31:0])};
    end else begin
      if (mag > 64'h7FFF_FFFF) r = {1'b1, S32_MAX};
      else                     r = {1'b0, mag[31:0]};
    end
    return r;
  endfunction

  // 33-bit sum to 32-bit signed, clamped. Returns {sat, value}.
  function automatic logic [32:0] sat_sum(input logic signed [32:0] v);
    logic [32:0] r;
    if (v[32] != v[31]) r = {1'b1, (v[32] ? S32_MIN : S32_MAX)};
    else                r = {1'b0, v[31:0]};
    return r;
  endfunction

  // |s| of a 66-bit accumulator; the values used never exceed 2^63.
  function automatic logic [63:0] abs66(input logic signed [65:0] s);
    logic [65:0] t;
    t = s[65] ? 66'(-s) : s;
    return t[63:0];
  endfunction

endpackage

// File: sv/cau_ctrl.sv
// Sequencer of the complex ALU: handshakes and datapath commands.
`include "complex_arithmetic_unit_core_assert.svh"
module cau_ctrl import cau_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] func_i,
  input  logic [7:0] exponent_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DIVP, S_DIV, S_DIVWB, S_SQP, S_SQRT, S_SQWB, S_FIN
  } state_e;

  state_e     state_q;
  logic [4:0] cnt_q;
  logic       pow_q;
  logic [7:0] pow_left_q;
  logic       out_valid_q;
  func_e      fn;

  assign fn          = func_e'(func_i);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.msel = MS_NONE;
    unique case (state_q)
      S_IDLE: cmd_o.load = in_valid_i;
      S_MUL: begin
        unique case (cnt_q)
          5'd0:    cmd_o.msel = MS_XRYR;
          5'd1:    cmd_o.msel = MS_XIYI;
          5'd2:    cmd_o.msel = MS_XRYI;
          5'd3:    cmd_o.msel = MS_XIYR;
          default: cmd_o.msel = MS_NONE;
        endcase
        cmd_o.mul_wb = (cnt_q == 5'd5);
      end
      S_DIVP: begin
        unique case (cnt_q)
          5'd0:    cmd_o.msel = MS_YRYR;
          5'd1:    cmd_o.msel = MS_YIYI;
          5'd2:    cmd_o.msel = MS_XRYR;
          5'd3:    cmd_o.msel = MS_XIYI;
          5'd4:    cmd_o.msel = MS_XRYI;
          5'd5:    cmd_o.msel = MS_XIYR;
          default: cmd_o.msel = MS_NONE;
        endcase
        cmd_o.div_init = (cnt_q == 5'd7);
      end
      S_DIV:   cmd_o.div_step = 1'b1;
      S_DIVWB: cmd_o.div_wb = 1'b1;
      S_SQP: begin
        unique case (cnt_q)
          5'd0:    cmd_o.msel = MS_YRYR;
          5'd1:    cmd_o.msel = MS_YIYI;
          default: cmd_o.msel = MS_NONE;
        endcase
        cmd_o.sqrt_init = (cnt_q == 5'd3);
      end
      S_SQRT:  cmd_o.sqrt_step = 1'b1;
      S_SQWB:  cmd_o.sqrt_wb = 1'b1;
      S_FIN:   cmd_o.fin = !out_valid_q || out_ready_i;
      default: cmd_o.msel = MS_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pow_q       <= 1'b0;
      pow_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.fin)        out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cnt_q      <= '0;
            pow_q      <= (fn == F_POW);
            pow_left_q <= exponent_i - 8'd1;
            unique case (fn) inside
              F_MUL, F_SQUARE, F_SCALE: state_q <= S_MUL;
              F_POW:                    state_q <= (exponent_i > 8'd1) ? S_MUL : S_FIN;
              F_DIV, F_INV, F_DIVREAL:  state_q <= S_DIVP;
              F_MOD:                    state_q <= S_SQP;
              default:                  state_q <= S_FIN;
            endcase
          end
        end
        S_MUL: begin
          if (cnt_q == 5'd5) begin
            cnt_q <= '0;
            if (pow_q && pow_left_q > 8'd1) pow_left_q <= pow_left_q - 8'd1;
            else                            state_q <= S_FIN;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_DIVP: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd7) begin
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) state_q <= S_DIVWB;
        end
        S_DIVWB: state_q <= S_FIN;
        S_SQP: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd3) begin
            cnt_q   <= '0;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) state_q <= S_SQWB;
        end
        S_SQWB: state_q <= S_FIN;
        S_FIN: begin
          if (cmd_o.fin) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `CAU_ASSERT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)
  `CAU_NEVER(a_fin_blocked, clk_i, rst_ni, cmd_o.fin && out_valid_q && !out_ready_i)
  `CAU_NEVER(a_pow_count, clk_i, rst_ni, state_q == S_MUL && pow_q && pow_left_q == 8'd0)
  `CAU_ASSERT(a_valid_src, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_FIN))

endmodule

// File: sv/cau_dp.sv
// Datapath of the complex ALU: shared multiplier, divider and square root.
module cau_dp import cau_pkg::*; (
  input  logic               clk_i,
  input  cmd_t               cmd_i,
  input  logic [3:0]         func_i,
  input  logic signed [31:0] a_re_i,
  input  logic signed [31:0] a_im_i,
  input  logic signed [31:0] b_re_i,
  input  logic signed [31:0] b_im_i,
  output logic signed [31:0] res_re_o,
  output logic signed [31:0] res_im_o,
  output logic [1:0]         status_o
);

  func_e              fn, op_q;
  logic signed [31:0] x_q [2];
  logic signed [31:0] y_q [2];
  logic signed [31:0] ld_x [2];
  logic signed [31:0] ld_y [2];
  logic               ld_sat;
  logic [32:0]        s_add_re, s_add_im, s_sub_re, s_sub_im, s_neg_im;

  logic signed [31:0] ma, mb;
  logic signed [63:0] p_d, p_q;
  logic signed [65:0] p_ext;
  msel_e              tag_q;
  logic               divmode;

  logic signed [65:0] acc_q [2];
  logic [63:0]        den_q;
  logic [64:0]        rem_q [2];
  logic [31:0]        q_q [2];
  logic [31:0]        nl_q [2];
  logic [1:0]         neg_q, ovf_q;
  logic               div0_q, sat_q;

  logic [63:0]        m_abs [2];
  logic [32:0]        mw_r [2];
  logic [32:0]        dw_r [2];
  logic [64:0]        r2 [2];
  logic [35:0]        sq_r2, sq_trial;
  logic [32:0]        sq_r;

  assign fn = func_e'(func_i);

  assign s_add_re = sat_sum(33'({a_re_i[31], a_re_i}) + 33'({b_re_i[31], b_re_i}));
  assign s_add_im = sat_sum(33'({a_im_i[31], a_im_i}) + 33'({b_im_i[31], b_im_i}));
  assign s_sub_re = sat_sum(33'({a_re_i[31], a_re_i}) - 33'({b_re_i[31], b_re_i}));
  assign s_sub_im = sat_sum(33'({a_im_i[31], a_im_i}) - 33'({b_im_i[31], b_im_i}));
  assign s_neg_im = sat_sum(33'd0 - 33'({a_im_i[31], a_im_i}));

  // x holds the working value (and the final result); y the multiplicand.
  always_comb begin
    ld_x[0] = a_re_i;
    ld_x[1] = a_im_i;
    ld_y[0] = a_re_i;
    ld_y[1] = a_im_i;
    ld_sat  = 1'b0;
    unique case (fn)
      F_ADD:     begin ld_x[0] = s_add_re[31:0]; ld_x[1] = s_add_im[31:0];
                       ld_sat = s_add_re[32] | s_add_im[32]; end
      F_SUB:     begin ld_x[0] = s_sub_re[31:0]; ld_x[1] = s_sub_im[31:0];
                       ld_sat = s_sub_re[32] | s_sub_im[32]; end
      F_CONJ:    begin ld_x[1] = s_neg_im[31:0]; ld_sat = s_neg_im[32]; end
      F_ADDREAL: begin ld_x[0] = s_add_re[31:0]; ld_sat = s_add_re[32]; end
      F_SUBREAL: begin ld_x[0] = s_sub_re[31:0]; ld_sat = s_sub_re[32]; end
      F_MUL, F_DIV: begin ld_y[0] = b_re_i; ld_y[1] = b_im_i; end
      F_SCALE, F_DIVREAL: begin ld_y[0] = b_re_i; ld_y[1] = '0; end
      F_INV:     begin ld_x[0] = Q_ONE; ld_x[1] = '0; end
      F_SQUARE, F_POW, F_MOD: ld_sat = 1'b0;
      default:   begin ld_x[0] = '0; ld_x[1] = '0; end
    endcase
  end

  always_comb begin
    unique case (cmd_i.msel)
      MS_XRYR: begin ma = x_q[0]; mb = y_q[0]; end
      MS_XIYI: begin ma = x_q[1]; mb = y_q[1]; end
      MS_XRYI: begin ma = x_q[0]; mb = y_q[1]; end
      MS_XIYR: begin ma = x_q[1]; mb = y_q[0]; end
      MS_YRYR: begin ma = y_q[0]; mb = y_q[0]; end
      MS_YIYI: begin ma = y_q[1]; mb = y_q[1]; end
      default: begin ma = '0;     mb = '0;     end
    endcase
  end

  assign p_d     = ma * mb;
  assign p_ext   = 66'(p_q);
  assign divmode = (op_q == F_DIV) || (op_q == F_INV) || (op_q == F_DIVREAL);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      m_abs[i] = abs66(acc_q[i]);
      mw_r[i]  = sat_mag(acc_q[i][65] && (m_abs[i] >> 16) != 64'd0, m_abs[i] >> 16);
      dw_r[i]  = sat_mag(neg_q[i] && (ovf_q[i] || q_q[i] != 32'd0),
                         ovf_q[i] ? 64'h1_0000_0000 : {32'd0, q_q[i]});
      r2[i]    = {rem_q[i][63:0], nl_q[i][31]};
    end
  end

  // Square root reuses lane 0 of the divider: rem as remainder, q as root.
  assign sq_r2    = {rem_q[0][33:0], den_q[63:62]};
  assign sq_trial = {2'b00, q_q[0], 2'b01};
  assign sq_r     = sat_mag(1'b0, {32'd0, q_q[0]});

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    tag_q <= cmd_i.msel;

    unique case (tag_q)
      MS_XRYR: acc_q[0] <= p_ext;
      MS_XIYI: acc_q[0] <= divmode ? acc_q[0] + p_ext : acc_q[0] - p_ext;
      MS_XRYI: acc_q[1] <= divmode ? -p_ext : p_ext;
      MS_XIYR: acc_q[1] <= acc_q[1] + p_ext;
      MS_YRYR: den_q <= p_q;
      MS_YIYI: den_q <= den_q + p_q;
      default: ;
    endcase

    if (cmd_i.load) begin
      op_q   <= fn;
      x_q    <= ld_x;
      y_q    <= ld_y;
      sat_q  <= ld_sat;
      div0_q <= 1'b0;
    end

    if (cmd_i.mul_wb) begin
      x_q[0] <= mw_r[0][31:0];
      x_q[1] <= mw_r[1][31:0];
      sat_q  <= sat_q | mw_r[0][32] | mw_r[1][32];
    end

    if (cmd_i.div_init) begin
      div0_q <= (den_q == 64'd0);
      for (int i = 0; i < 2; i++) begin
        neg_q[i] <= acc_q[i][65];
        ovf_q[i] <= {16'd0, m_abs[i][63:16]} >= den_q;
        rem_q[i] <= {17'd0, m_abs[i][63:16]};
        nl_q[i]  <= {m_abs[i][15:0], 16'd0};
        q_q[i]   <= '0;
      end
    end

    if (cmd_i.div_step) begin
      for (int i = 0; i < 2; i++) begin
        if (r2[i] >= {1'b0, den_q}) begin
          rem_q[i] <= r2[i] - {1'b0, den_q};
          q_q[i]   <= {q_q[i][30:0], 1'b1};
        end else begin
          rem_q[i] <= r2[i];
          q_q[i]   <= {q_q[i][30:0], 1'b0};
        end
        nl_q[i] <= {nl_q[i][30:0], 1'b0};
      end
    end

    if (cmd_i.div_wb) begin
      if (div0_q) begin
        x_q[0] <= x_q[0][31] ? S32_MIN : S32_MAX;
        x_q[1] <= x_q[1][31] ? S32_MIN : S32_MAX;
      end else begin
        x_q[0] <= dw_r[0][31:0];
        x_q[1] <= dw_r[1][31:0];
        sat_q  <= sat_q | dw_r[0][32] | dw_r[1][32];
      end
    end

    if (cmd_i.sqrt_init) begin
      rem_q[0] <= '0;
      q_q[0]   <= '0;
    end

    if (cmd_i.sqrt_step) begin
      if (sq_r2 >= sq_trial) begin
        rem_q[0] <= 65'(34'(sq_r2 - sq_trial));
        q_q[0]   <= {q_q[0][30:0], 1'b1};
      end else begin
        rem_q[0] <= 65'(sq_r2[33:0]);
        q_q[0]   <= {q_q[0][30:0], 1'b0};
      end
      den_q <= {den_q[61:0], 2'b00};
    end

    if (cmd_i.sqrt_wb) begin
      x_q[0] <= sq_r[31:0];
      x_q[1] <= '0;
      sat_q  <= sat_q | sq_r[32];
    end

    if (cmd_i.fin) begin
      res_re_o <= x_q[0];
      res_im_o <= x_q[1];
      status_o <= div0_q ? ST_DIV0 : (sat_q ? ST_SAT : ST_OK);
    end
  end

endmodule

// File: sv/complex_arithmetic_unit_core.sv
// Top level of the complex ALU: sequencer plus datapath.
//
// Complex arithmetic on signed Q16.16 operands. One item enters on the
// input channel (in_valid_i/in_ready_o) with func_i, a, b and exponent_i;
// exactly one result transfer leaves on the output channel
// (out_valid_o/out_ready_i) with res_re_o, res_im_o and status_o
// (0 ok, 1 divide by zero, 2 saturated).
// One item is in work at a time; in_ready_o is high only when idle.
// Work done per function after the input transfer, as set by the sequencer:
//   add, sub, conj, addreal, subreal, unused codes: result formed at load
//   mul, square, scale: four products through one 32x32 multiplier
//   pow: exponent - 1 multiply passes, none for exponent 0 or 1
//   div, inverse, divreal: six products, 32-step restoring divide
//   mod: two products, 32-step restoring square root
// A new item is not taken until the sequencer is idle again.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls, a finished item holds in the sequencer
// until the output register frees up. Reset clears the control state and
// drops any pending result; no clearing pass is needed.
module complex_arithmetic_unit_core import cau_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         func_i,
  input  logic signed [31:0] a_re_i,
  input  logic signed [31:0] a_im_i,
  input  logic signed [31:0] b_re_i,
  input  logic signed [31:0] b_im_i,
  input  logic [7:0]         exponent_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] res_re_o,
  output logic signed [31:0] res_im_o,
  output logic [1:0]         status_o
);

  // Command bundle from the sequencer into the datapath.
  cmd_t cmd;

  cau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .exponent_i  (exponent_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Operands are captured on the load command, i.e. on the input transfer.
  cau_dp u_dp (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .func_i   (func_i),
    .a_re_i   (a_re_i),
    .a_im_i   (a_im_i),
    .b_re_i   (b_re_i),
    .b_im_i   (b_im_i),
    .res_re_o (res_re_o),
    .res_im_o (res_im_o),
    .status_o (status_o)
  );

endmodule
